### src/rgb_to_hsv_converter_defines.svh
// Assertion macros for the top-level converter, which carries the concurrent checks.
`ifndef RGB_TO_HSV_CONVERTER_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RHC_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define RHC_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/rhc_pkg.sv
`timescale 1ns / 1ps

package rhc_pkg;

	// Default sizes of a colour channel and of the fixed-point fractions.
	localparam int CHANNEL_BITS_DEF  = 8;
	localparam int FRACTION_BITS_DEF = 16;

	// Extra bits that hold six times delta, the hue divisor.
	localparam int SECTOR_BITS = 3;

endpackage

### src/rhc_front.sv
`timescale 1ns / 1ps

module rhc_front #(
	parameter int CHANNEL_BITS = rhc_pkg::CHANNEL_BITS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          in_valid,
	output logic                                          in_ready,
	input  logic [CHANNEL_BITS-1:0]                       red,
	input  logic [CHANNEL_BITS-1:0]                       green,
	input  logic [CHANNEL_BITS-1:0]                       blue,
	output logic                                          out_valid,
	input  logic                                          out_ready,
	output logic [CHANNEL_BITS-1:0]                       value,
	output logic [CHANNEL_BITS-1:0]                       sat_num,
	output logic [CHANNEL_BITS-1:0]                       sat_den,
	output logic [CHANNEL_BITS+rhc_pkg::SECTOR_BITS-1:0]  hue_num,
	output logic [CHANNEL_BITS+rhc_pkg::SECTOR_BITS-1:0]  hue_den
);
	import rhc_pkg::*;

	localparam int HB = CHANNEL_BITS + SECTOR_BITS;

	logic [CHANNEL_BITS-1:0] hi;
	logic [CHANNEL_BITS-1:0] lo;
	logic [CHANNEL_BITS-1:0] delta;
	logic [HB-1:0]           full;
	logic [HB-1:0]           red_tmp;
	logic [HB-1:0]           num;
	logic                    red_max;
	logic                    green_max;

	logic                    vld_s1;
	logic [CHANNEL_BITS-1:0] value_s1;
	logic [CHANNEL_BITS-1:0] sat_num_s1;
	logic [CHANNEL_BITS-1:0] sat_den_s1;
	logic [HB-1:0]           hue_num_s1;
	logic [HB-1:0]           hue_den_s1;

	always_comb begin
		hi = red;
		lo = red;
		if (green > hi) hi = green;
		if (blue > hi) hi = blue;
		if (green < lo) lo = green;
		if (blue < lo) lo = blue;
		delta = hi - lo;
		full  = HB'({delta, 2'b00}) + HB'({delta, 1'b0});

		// Ties between channels go to red first, then green.
		red_max   = (red >= green) && (red >= blue);
		green_max = (green >= blue);

		red_tmp = HB'(green) + full - HB'(blue);
		if (red_max) begin
			num = (red_tmp >= full) ? (red_tmp - full) : red_tmp;
		end else if (green_max) begin
			num = HB'({delta, 1'b0}) + HB'(blue) - HB'(red);
		end else begin
			num = HB'({delta, 2'b00}) + HB'(red) - HB'(green);
		end
	end

	assign in_ready = !vld_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	// A grey or black pixel gives hue zero over one; black also gives saturation zero over one.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			value_s1   <= hi;
			sat_num_s1 <= delta;
			sat_den_s1 <= (hi == '0) ? CHANNEL_BITS'(1) : hi;
			hue_num_s1 <= (delta == '0) ? '0 : num;
			hue_den_s1 <= (delta == '0) ? HB'(1) : full;
		end
	end

	assign out_valid = vld_s1;
	assign value     = value_s1;
	assign sat_num   = sat_num_s1;
	assign sat_den   = sat_den_s1;
	assign hue_num   = hue_num_s1;
	assign hue_den   = hue_den_s1;

endmodule

### src/rhc_div.sv
`timescale 1ns / 1ps

module rhc_div #(
	parameter int CHANNEL_BITS  = rhc_pkg::CHANNEL_BITS_DEF,
	parameter int FRACTION_BITS = rhc_pkg::FRACTION_BITS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          in_valid,
	output logic                                          in_ready,
	input  logic [CHANNEL_BITS-1:0]                       value_in,
	input  logic [CHANNEL_BITS-1:0]                       sat_num,
	input  logic [CHANNEL_BITS-1:0]                       sat_den,
	input  logic [CHANNEL_BITS+rhc_pkg::SECTOR_BITS-1:0]  hue_num,
	input  logic [CHANNEL_BITS+rhc_pkg::SECTOR_BITS-1:0]  hue_den,
	output logic                                          out_valid,
	input  logic                                          out_ready,
	output logic [FRACTION_BITS-1:0]                      hue,
	output logic [FRACTION_BITS:0]                        saturation,
	output logic [CHANNEL_BITS-1:0]                       value
);
	import rhc_pkg::*;

	localparam int HB   = CHANNEL_BITS + SECTOR_BITS;
	localparam int QB   = FRACTION_BITS + 1;
	localparam int NSTG = FRACTION_BITS + 1;

	logic                    vld_s     [NSTG];
	logic [CHANNEL_BITS-1:0] value_s   [NSTG];
	logic [CHANNEL_BITS-1:0] sat_den_s [NSTG];
	logic [CHANNEL_BITS-1:0] sat_rem_s [NSTG];
	logic [QB-1:0]           sat_quo_s [NSTG];
	logic [HB-1:0]           hue_den_s [NSTG];
	logic [HB-1:0]           hue_rem_s [NSTG];
	logic [QB-1:0]           hue_quo_s [NSTG];
	logic                    rdy       [NSTG+1];

	assign rdy[NSTG] = out_ready;
	assign in_ready  = rdy[0];

	// Each stage yields one quotient bit of both divisions: the first stage the
	// integer bit, the others one fraction bit each.
	for (genvar k = 0; k < NSTG; k++) begin : g_stage
		logic                    prev_vld;
		logic [CHANNEL_BITS-1:0] prev_value;
		logic [CHANNEL_BITS-1:0] prev_sat_den;
		logic [HB-1:0]           prev_hue_den;
		logic [QB-1:0]           prev_sat_quo;
		logic [QB-1:0]           prev_hue_quo;
		logic [CHANNEL_BITS:0]   sat_trial;
		logic [HB:0]             hue_trial;
		logic                    sat_ge;
		logic                    hue_ge;
		logic [CHANNEL_BITS:0]   sat_diff;
		logic [HB:0]             hue_diff;

		if (k == 0) begin : g_first
			assign prev_vld     = in_valid;
			assign prev_value   = value_in;
			assign prev_sat_den = sat_den;
			assign prev_hue_den = hue_den;
			assign prev_sat_quo = '0;
			assign prev_hue_quo = '0;
			assign sat_trial    = {1'b0, sat_num};
			assign hue_trial    = {1'b0, hue_num};
		end else begin : g_rest
			assign prev_vld     = vld_s[k-1];
			assign prev_value   = value_s[k-1];
			assign prev_sat_den = sat_den_s[k-1];
			assign prev_hue_den = hue_den_s[k-1];
			assign prev_sat_quo = sat_quo_s[k-1];
			assign prev_hue_quo = hue_quo_s[k-1];
			assign sat_trial    = {sat_rem_s[k-1], 1'b0};
			assign hue_trial    = {hue_rem_s[k-1], 1'b0};
		end

		assign sat_ge   = sat_trial >= {1'b0, prev_sat_den};
		assign hue_ge   = hue_trial >= {1'b0, prev_hue_den};
		assign sat_diff = sat_ge ? (sat_trial - {1'b0, prev_sat_den}) : sat_trial;
		assign hue_diff = hue_ge ? (hue_trial - {1'b0, prev_hue_den}) : hue_trial;

		assign rdy[k] = !vld_s[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= prev_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && prev_vld) begin
				value_s[k]   <= prev_value;
				sat_den_s[k] <= prev_sat_den;
				hue_den_s[k] <= prev_hue_den;
				sat_rem_s[k] <= sat_diff[CHANNEL_BITS-1:0];
				hue_rem_s[k] <= hue_diff[HB-1:0];
				sat_quo_s[k] <= {prev_sat_quo[QB-2:0], sat_ge};
				hue_quo_s[k] <= {prev_hue_quo[QB-2:0], hue_ge};
			end
		end
	end

	assign out_valid  = vld_s[NSTG-1];
	assign value      = value_s[NSTG-1];
	assign saturation = sat_quo_s[NSTG-1];
	assign hue        = hue_quo_s[NSTG-1][FRACTION_BITS-1:0];

endmodule

### src/rgb_to_hsv_converter.sv
// RGB to HSV colour converter, one pixel per beat.
// Path: the front register, then the divider stages; the last stage is the output register.
// Throughput: one pixel per cycle while m_tready is high; the divider pipeline takes one quotient bit per stage.
// Reset: arst_n clears only the stage valid bits; data registers are not reset.
`timescale 1ns / 1ps

`include "rgb_to_hsv_converter_defines.svh"

module rgb_to_hsv_converter #(
	parameter int CHANNEL_BITS  = rhc_pkg::CHANNEL_BITS_DEF,
	parameter int FRACTION_BITS = rhc_pkg::FRACTION_BITS_DEF
) (
	input  logic                                                   clk,
	input  logic                                                   arst_n,
	input  logic                                                   s_tvalid,
	output logic                                                   s_tready,
	// Fields from bit 0 up: red, green, blue, then zero padding.
	input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0]                    s_tdata,
	output logic                                                   m_tvalid,
	input  logic                                                   m_tready,
	// Fields from bit 0 up: hue, saturation, value, then zero padding.
	output logic [((2*FRACTION_BITS+1+CHANNEL_BITS+7)/8)*8-1:0]    m_tdata
);
	import rhc_pkg::*;

	localparam int HB    = CHANNEL_BITS + SECTOR_BITS;
	localparam int OUT_W = ((2*FRACTION_BITS+1+CHANNEL_BITS+7)/8)*8;
	localparam logic [FRACTION_BITS:0] SAT_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

	// The front stage finds the largest and smallest channel, delta and the
	// sector numerator of the hue. It hands both divisions to the divider as
	// numerator and divisor pairs; a grey or black pixel gets a zero numerator
	// over a nonzero divisor so that the divider needs no special case.
	logic                    front_valid;
	logic                    front_ready;
	logic [CHANNEL_BITS-1:0] front_value;
	logic [CHANNEL_BITS-1:0] front_sat_num;
	logic [CHANNEL_BITS-1:0] front_sat_den;
	logic [HB-1:0]           front_hue_num;
	logic [HB-1:0]           front_hue_den;

	logic [FRACTION_BITS-1:0] hue_w;
	logic [FRACTION_BITS:0]   sat_w;
	logic [CHANNEL_BITS-1:0]  value_w;

	rhc_front #(
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.red       (s_tdata[CHANNEL_BITS-1:0]),
		.green     (s_tdata[2*CHANNEL_BITS-1:CHANNEL_BITS]),
		.blue      (s_tdata[3*CHANNEL_BITS-1:2*CHANNEL_BITS]),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.value     (front_value),
		.sat_num   (front_sat_num),
		.sat_den   (front_sat_den),
		.hue_num   (front_hue_num),
		.hue_den   (front_hue_den)
	);

	// The divider runs both restoring divisions side by side, one quotient bit
	// per stage. Every stage has its own valid bit and a ready that is open when
	// the stage is empty or the next one is ready, so bubbles are squeezed out while the output is
	// stalled and the front keeps taking beats until the pipe is full. The
	// last stage doubles as the output register.
	rhc_div #(
		.CHANNEL_BITS  (CHANNEL_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (front_valid),
		.in_ready   (front_ready),
		.value_in   (front_value),
		.sat_num    (front_sat_num),
		.sat_den    (front_sat_den),
		.hue_num    (front_hue_num),
		.hue_den    (front_hue_den),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.hue        (hue_w),
		.saturation (sat_w),
		.value      (value_w)
	);

	assign m_tdata = OUT_W'({value_w, sat_w, hue_w});

	// Saturation never exceeds one, since delta is at most the value.
	`RHC_ASSERT_IMP(a_sat_bound, clk, arst_n, m_tvalid, sat_w <= SAT_ONE, "saturation above one")

	// A black pixel has no saturation.
	`RHC_ASSERT_IMP(a_black_sat, clk, arst_n, m_tvalid && (value_w == '0), sat_w == '0, "black pixel saturated")

	// With the output register empty the whole ready chain is open.
	`RHC_ASSERT_IMP(a_open_pipe, clk, arst_n, !m_tvalid, s_tready, "input blocked with empty output")

endmodule

### tb/rgb_to_hsv_checker.sv
`timescale 1ns / 1ps

// Watches both streams of the converter. For every pixel beat it queues the HSV triple the
// block should return. Every result beat is compared with the oldest triple in the queue.
module rgb_to_hsv_checker #(
	parameter int CB    = rhc_pkg::CHANNEL_BITS_DEF,
	parameter int FB    = rhc_pkg::FRACTION_BITS_DEF,
	parameter int IN_W  = ((3*CB+7)/8)*8,
	parameter int OUT_W = ((2*FB+1+CB+7)/8)*8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [OUT_W-1:0] m_tdata,
	output int               fail_count,
	output int               results_checked,
	output int               outstanding
);

	localparam int SB = rhc_pkg::SECTOR_BITS;

	typedef struct packed {
		logic [FB-1:0] hue;
		logic [FB:0]   sat;
		logic [CB-1:0] value;
	} hsv_t;

	hsv_t hsv_due[$];
	int   fails   = 0;
	int   checked = 0;

	// Fixed-point HSV of one pixel. Ties on the largest channel go to red, then green.
	function automatic hsv_t predict_hsv(input logic [CB-1:0] r, g, b);
		logic [CB-1:0]       hi, lo, delta;
		logic [CB+FB-1:0]    delta_frac;
		logic [CB+SB-1:0]    six_delta, sector_num;
		logic [CB+SB+FB-1:0] num_frac;
		hsv_t                res;
		hi = r;
		lo = r;
		if (g > hi) hi = g;
		if (b > hi) hi = b;
		if (g < lo) lo = g;
		if (b < lo) lo = b;
		delta = hi - lo;
		res.value = hi;
		res.sat = '0;
		res.hue = '0;
		if (hi != 0) begin
			delta_frac = {delta, {FB{1'b0}}};
			res.sat = (FB+1)'(delta_frac / hi);
		end
		if (delta != 0) begin
			six_delta = (CB+SB)'(6 * delta);
			if (r >= g && r >= b) begin
				// Red sector: G - B, brought back into range when it went negative.
				sector_num = g + six_delta - b;
				if (sector_num >= six_delta) sector_num = sector_num - six_delta;
			end else if (g >= b) begin
				sector_num = (CB+SB)'(2 * delta + b - r);
			end else begin
				sector_num = (CB+SB)'(4 * delta + r - g);
			end
			num_frac = {sector_num, {FB{1'b0}}};
			res.hue = FB'(num_frac / six_delta);
		end
		return res;
	endfunction

	always @(posedge clk) begin : watch
		hsv_t got, want;
		if (arst_n) begin
			// The result side goes first; a pixel can never leave in the cycle it enters.
			if (m_tvalid && m_tready) begin
				got.hue   = m_tdata[FB-1:0];
				got.sat   = m_tdata[2*FB:FB];
				got.value = m_tdata[2*FB+CB:2*FB+1];
				if (hsv_due.size() == 0) begin
					$error("result beat with no pixel waiting: hue %0d, saturation %0d, value %0d",
						got.hue, got.sat, got.value);
					fails++;
				end else begin
					want = hsv_due.pop_front();
					checked++;
					if (got.hue !== want.hue) begin
						$error("hue: expected %0d, actual %0d", want.hue, got.hue);
						fails++;
					end
					if (got.sat !== want.sat) begin
						$error("saturation: expected %0d, actual %0d", want.sat, got.sat);
						fails++;
					end
					if (got.value !== want.value) begin
						$error("value: expected %0d, actual %0d", want.value, got.value);
						fails++;
					end
				end
				if ((m_tdata >> (2*FB+1+CB)) !== '0) begin
					$error("padding: expected 0, actual %0h", m_tdata >> (2*FB+1+CB));
					fails++;
				end
			end
			if (s_tvalid && s_tready)
				hsv_due.push_back(predict_hsv(s_tdata[CB-1:0], s_tdata[2*CB-1:CB],
					s_tdata[3*CB-1:2*CB]));
		end
		fail_count      <= fails;
		results_checked <= checked;
		outstanding     <= hsv_due.size();
	end

endmodule

### tb/rgb_to_hsv_converter_tb.sv
`timescale 1ns / 1ps

// Top of the converter testbench. It produces the pixel stream and the back-pressure on the
// result stream. It also gives the verdict. All prediction and comparison is done in the
// checker, which sits beside the block and watches both streams.
module rgb_to_hsv_converter_tb;

	localparam int            CB          = rhc_pkg::CHANNEL_BITS_DEF;
	localparam int            FB          = rhc_pkg::FRACTION_BITS_DEF;
	localparam int            IN_W        = ((3*CB+7)/8)*8;
	localparam int            OUT_W       = ((2*FB+1+CB+7)/8)*8;
	localparam logic [CB-1:0] MAXC        = '1;
	// The pipeline is FB + 2 stages deep. A hold-off well past that fills the block.
	localparam int            HOLD_CYCLES = 80;
	localparam int            HOLD_BEATS  = 70;
	localparam int            RANDOM_PIX  = 440;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	// Fields from bit 0 up: red, green, blue, then zero padding.
	logic [IN_W-1:0]  s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	// Fields from bit 0 up: hue, saturation, value, then zero padding.
	logic [OUT_W-1:0] m_tdata;

	int fail_count;
	int results_checked;
	int outstanding;

	// Sender bookkeeping. burst_left counts the beats left before the next gap.
	int burst_left     = 1;
	int pixels_sent    = 0;
	int directed_count = 0;
	int drain_count    = 0;
	// The stimulus raises this count to ask the receiver for one long hold-off.
	int hold_requests  = 0;

	always #6 clk = ~clk;

	rgb_to_hsv_converter u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	rgb_to_hsv_checker #(
		.CB    (CB),
		.FB    (FB),
		.IN_W  (IN_W),
		.OUT_W (OUT_W)
	) u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.fail_count      (fail_count),
		.results_checked (results_checked),
		.outstanding     (outstanding)
	);

	// Offers one pixel and waits for the beat to be accepted. tvalid stays high across a
	// burst. At the end of a burst the sender may drop tvalid for a random gap. A gap of
	// zero means that the next burst follows back to back.
	task automatic send_pixel(input logic [CB-1:0] r, g, b);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= IN_W'({b, g, r});
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pixels_sent++;
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
	endtask

	// Stops offering pixels until every pixel in flight has come back. The task waits on the
	// clock before it checks, so tvalid is never lowered and raised again in the same step.
	task automatic drain_pipeline();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		burst_left = $urandom_range(1, 24);
		drain_count++;
	endtask

	// Random pixels, weighted towards the corners of the conversion: grey pixels, ties on
	// the largest channel, nearly grey pixels, channels at 0 or full scale, and pure hues.
	task automatic send_random_pixel();
		int c[3];
		int v, w, pick;
		v = $urandom_range(0, MAXC);
		case ($urandom_range(0, 9))
			4: begin
				c[0] = v; c[1] = v; c[2] = v;
			end
			5: begin
				pick = $urandom_range(0, 2);
				for (int i = 0; i < 3; i++) c[i] = v;
				c[pick] = $urandom_range(0, v);
			end
			6: begin
				w = $urandom_range(0, MAXC - 3);
				for (int i = 0; i < 3; i++) c[i] = w + $urandom_range(0, 3);
			end
			7: begin
				for (int i = 0; i < 3; i++) begin
					case ($urandom_range(0, 2))
						0:       c[i] = 0;
						1:       c[i] = MAXC;
						default: c[i] = $urandom_range(0, MAXC);
					endcase
				end
			end
			8: begin
				pick = $urandom_range(1, 7);
				for (int i = 0; i < 3; i++) c[i] = pick[i] ? v : 0;
			end
			9: begin
				pick = $urandom_range(0, 2);
				w = $urandom_range(0, v);
				for (int i = 0; i < 3; i++) c[i] = w;
				c[pick] = v;
			end
			default: begin
				for (int i = 0; i < 3; i++) c[i] = $urandom_range(0, MAXC);
			end
		endcase
		send_pixel(CB'(c[0]), CB'(c[1]), CB'(c[2]));
	endtask

	// The receiver changes its pattern from one stretch to the next. The patterns are always
	// ready, a coin toss per cycle, a periodic pulse of ready, and rare random stalls. A hold-off
	// request overrides the pattern. It holds tready low while
	// the sender keeps on offering pixels.
	initial begin : receiver
		int mode, stretch, period, served;
		served = 0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			mode    = $urandom_range(0, 3);
			stretch = $urandom_range(4, 60);
			period  = $urandom_range(2, 5);
			for (int i = 0; i < stretch; i++) begin
				@(posedge clk);
				if (hold_requests != served) begin
					served = hold_requests;
					m_tready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
				end
				case (mode)
					0:       m_tready <= 1'b1;
					1:       m_tready <= 1'($urandom_range(0, 1));
					2:       m_tready <= (i % period) == 0;
					default: m_tready <= $urandom_range(0, 7) != 0;
				endcase
			end
		end
	end

	// A fixed limit on the whole run. A correct run takes a small fraction of it.
	initial begin : watchdog
		#5ms;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pixels. These cover black, white and grey, and the primaries and
		// secondaries. They cover ties between two largest channels, a red sector that
		// wraps below zero, and pixels whose saturation is just above zero. They also cover
		// pixels whose value is only one.
		send_pixel(0, 0, 0);
		send_pixel(MAXC, MAXC, MAXC);
		send_pixel(128, 128, 128);
		send_pixel(1, 1, 1);
		send_pixel(MAXC, 0, 0);
		send_pixel(0, MAXC, 0);
		send_pixel(0, 0, MAXC);
		send_pixel(MAXC, MAXC, 0);
		send_pixel(0, MAXC, MAXC);
		send_pixel(MAXC, 0, MAXC);
		send_pixel(MAXC, 0, 1);
		send_pixel(200, 50, 100);
		send_pixel(MAXC, MAXC - 1'b1, MAXC - 1'b1);
		send_pixel(MAXC, MAXC, MAXC - 1'b1);
		send_pixel(1, 0, 0);
		send_pixel(0, 1, 0);
		send_pixel(0, 0, 1);
		send_pixel(2, 1, 0);
		send_pixel(100, 200, 50);
		send_pixel(60, 30, 240);
		send_pixel(170, 85, 0);
		send_pixel(85, 170, MAXC);
		send_pixel(0, MAXC, 1);
		directed_count = pixels_sent;
		drain_pipeline();

		// Back-pressure. The receiver holds off while a long burst keeps arriving. The
		// pipeline fills up and s_tready has to drop.
		hold_requests++;
		burst_left = HOLD_BEATS;
		for (int i = 0; i < HOLD_BEATS; i++) send_random_pixel();
		drain_pipeline();

		// The bulk of the run. Now and then the sender waits for the pipeline to empty.
		for (int i = 0; i < RANDOM_PIX; i++) begin
			if ($urandom_range(0, 119) == 0) drain_pipeline();
			if (i == RANDOM_PIX / 2) begin
				hold_requests++;
				burst_left = HOLD_BEATS / 2;
			end
			send_random_pixel();
		end

		drain_pipeline();
		// Let any stray result beat show up before the verdict.
		repeat (FB + 2 + 20) @(posedge clk);

		$display("Summary: %0d pixels (%0d directed, the rest random with grey, tie and",
			pixels_sent, directed_count);
		$display("  extreme mixes), %0d results compared, %0d hold-offs, %0d full drains.",
			results_checked, hold_requests, drain_count);
		if (outstanding != 0)
			$error("%0d expected results never arrived", outstanding);
		if (fail_count == 0 && outstanding == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+src
src/rhc_pkg.sv
src/rhc_front.sv
src/rhc_div.sv
src/rgb_to_hsv_converter.sv
tb/rgb_to_hsv_checker.sv
tb/rgb_to_hsv_converter_tb.sv
